### src/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg - shared types and constants for the scaled decimal compare unit
// Field widths, result codes, sequencer states and control/status bundles.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int MANT_LOW_W  = 64;
    localparam int MANT_HIGH_W = 32;
    localparam int MANT_W      = MANT_LOW_W + MANT_HIGH_W;
    localparam int SCALE_W     = 5;

    localparam int DEF_MAX_SCALE = 28;
    localparam int DEF_WORK_BITS = 224;

    // s_tdata layout, lowest bit first
    localparam int A_LOW_LSB  = 0;
    localparam int A_HIGH_LSB = A_LOW_LSB + MANT_LOW_W;
    localparam int A_SCL_LSB  = A_HIGH_LSB + MANT_HIGH_W;
    localparam int A_NEG_LSB  = A_SCL_LSB + SCALE_W;
    localparam int B_LOW_LSB  = A_NEG_LSB + 1;
    localparam int B_HIGH_LSB = B_LOW_LSB + MANT_LOW_W;
    localparam int B_SCL_LSB  = B_HIGH_LSB + MANT_HIGH_W;
    localparam int B_NEG_LSB  = B_SCL_LSB + SCALE_W;
    localparam int IN_BITS    = B_NEG_LSB + 1;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } align_ctrl_t;

    typedef struct packed {
        logic done;
    } align_stat_t;

endpackage

### src/sdc_align_unit.sv
// ----------------------------------------------------------------------------
// sdc_align_unit - scale alignment by repeated multiply-by-ten
// Holds both working magnitudes and steps the smaller-scale one by ten,
// one shared shift-and-add per cycle while step is high, until the scales match.
// ----------------------------------------------------------------------------
module sdc_align_unit #(
    parameter int MAX_SCALE = sdc_pkg::DEF_MAX_SCALE,
    parameter int WORK_BITS = sdc_pkg::DEF_WORK_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sdc_pkg::align_ctrl_t        ctrl,
    input  logic [sdc_pkg::MANT_W-1:0]  mant_a,
    input  logic [sdc_pkg::MANT_W-1:0]  mant_b,
    input  logic [sdc_pkg::SCALE_W-1:0] scale_a,
    input  logic [sdc_pkg::SCALE_W-1:0] scale_b,
    output sdc_pkg::align_stat_t        stat,
    output logic [WORK_BITS-1:0]        mag_a,
    output logic [WORK_BITS-1:0]        mag_b
);

    localparam int CNT_W = (MAX_SCALE < 2) ? 1 : $clog2(MAX_SCALE + 1);
    localparam logic [sdc_pkg::SCALE_W-1:0] MAX_S = sdc_pkg::SCALE_W'(MAX_SCALE);

    logic [WORK_BITS-1:0]        mag_a_reg, mag_a_next;
    logic [WORK_BITS-1:0]        mag_b_reg, mag_b_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        sel_b_reg, sel_b_next;
    logic [sdc_pkg::SCALE_W-1:0] sa, sb, diff;
    logic [WORK_BITS-1:0]        op, ten_op;

    // saturate scales above the limit
    assign sa = (scale_a > MAX_S) ? MAX_S : scale_a;
    assign sb = (scale_b > MAX_S) ? MAX_S : scale_b;
    assign diff = (sa < sb) ? (sb - sa) : (sa - sb);

    // shared unit: x*10 = (x << 3) + (x << 1), truncated to working width
    assign op     = sel_b_reg ? mag_b_reg : mag_a_reg;
    assign ten_op = {op[WORK_BITS-4:0], 3'b000} + {op[WORK_BITS-2:0], 1'b0};

    always_comb begin
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        cnt_next   = cnt_reg;
        sel_b_next = sel_b_reg;
        if (ctrl.load) begin
            mag_a_next = WORK_BITS'(mant_a);
            mag_b_next = WORK_BITS'(mant_b);
            cnt_next   = diff[CNT_W-1:0];
            sel_b_next = (sb < sa);
        end else if (ctrl.step && (cnt_reg != '0)) begin
            if (sel_b_reg) begin
                mag_b_next = ten_op;
            end else begin
                mag_a_next = ten_op;
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sel_b_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            sel_b_reg <= sel_b_next;
        end
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
    end

    assign stat.done = (cnt_reg == '0);
    assign mag_a     = mag_a_reg;
    assign mag_b     = mag_b_reg;

    // each step takes exactly one off the remaining count
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.load && cnt_reg != '0) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("alignment count did not decrement");

    // only the selected operand moves while stepping
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.load) |=> ($stable(mag_a_reg) || $stable(mag_b_reg)))
        else $error("both magnitudes changed in one step");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl.step && !ctrl.load) |=> ($stable(cnt_reg) && $stable(sel_b_reg)))
        else $error("alignment state changed without a command");

endmodule

### src/sdc_order.sv
// ----------------------------------------------------------------------------
// sdc_order - signed order of two aligned magnitudes
// Zeros of either sign are equal; otherwise sign first, then magnitude,
// with the magnitude result inverted when both are negative.
// ----------------------------------------------------------------------------
module sdc_order #(
    parameter int WORK_BITS = sdc_pkg::DEF_WORK_BITS
) (
    input  logic [WORK_BITS-1:0] mag_a,
    input  logic [WORK_BITS-1:0] mag_b,
    input  logic                 neg_a,
    input  logic                 neg_b,
    output sdc_pkg::order_t      order
);

    logic zero_both;
    logic mag_gt, mag_lt;

    assign zero_both = (mag_a == '0) && (mag_b == '0);
    assign mag_gt    = (mag_a > mag_b);
    assign mag_lt    = (mag_a < mag_b);

    always_comb begin
        if (zero_both) begin
            order = sdc_pkg::ORD_EQUAL;
        end else if (neg_a && !neg_b) begin
            order = sdc_pkg::ORD_LESS;
        end else if (!neg_a && neg_b) begin
            order = sdc_pkg::ORD_GREATER;
        end else if (mag_gt) begin
            order = neg_a ? sdc_pkg::ORD_LESS : sdc_pkg::ORD_GREATER;
        end else if (mag_lt) begin
            order = neg_a ? sdc_pkg::ORD_GREATER : sdc_pkg::ORD_LESS;
        end else begin
            order = sdc_pkg::ORD_EQUAL;
        end
    end

endmodule

### src/scaled_decimal_compare_unit.sv
// ----------------------------------------------------------------------------
// scaled_decimal_compare_unit - signed scaled decimal comparator
// Compares two (-1)^sign * mantissa / 10^scale operands, one at a time.
// ----------------------------------------------------------------------------
// Each input transfer carries two operands, each a 96-bit mantissa, a scale
// of 0..MAX_SCALE (larger codes saturate) and a sign; one output transfer
// returns the order of A to B: less, equal or greater. Zeros of either sign
// compare equal. An accepted item is loaded, the smaller-scale mantissa is
// multiplied by ten |scale_a - scale_b| times through the single shared
// multiply-by-ten adder, and the aligned pair is then compared into the
// output register. s_tready is high only while the unit is idle. The result
// sits in an output register, so a new item is taken while the previous
// result waits for m_tready.
// ----------------------------------------------------------------------------
module scaled_decimal_compare_unit #(
    parameter int MAX_SCALE = sdc_pkg::DEF_MAX_SCALE,
    parameter int WORK_BITS = sdc_pkg::DEF_WORK_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata, lowest bit up: a_mant_low[63:0], a_mant_high[95:64],
    // a_scale[100:96], a_negative[101], b_mant_low[165:102],
    // b_mant_high[197:166], b_scale[202:198], b_negative[203], zero pad
    input  logic [sdc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata, lowest bit up: order[1:0], zero pad
    output logic [sdc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    sdc_pkg::state_t      state_reg, state_next;
    sdc_pkg::align_ctrl_t ctrl;
    sdc_pkg::align_stat_t stat;
    sdc_pkg::order_t      order_reg, order_next, cmp_order;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 neg_a_reg, neg_a_next;
    logic                 neg_b_reg, neg_b_next;
    logic                 in_xfer, out_free;

    logic [sdc_pkg::MANT_W-1:0]  mant_a, mant_b;
    logic [sdc_pkg::SCALE_W-1:0] scale_a, scale_b;
    logic [WORK_BITS-1:0]        mag_a, mag_b;

    // unpack the input transfer
    assign mant_a  = {s_tdata[sdc_pkg::A_HIGH_LSB +: sdc_pkg::MANT_HIGH_W],
                      s_tdata[sdc_pkg::A_LOW_LSB  +: sdc_pkg::MANT_LOW_W]};
    assign mant_b  = {s_tdata[sdc_pkg::B_HIGH_LSB +: sdc_pkg::MANT_HIGH_W],
                      s_tdata[sdc_pkg::B_LOW_LSB  +: sdc_pkg::MANT_LOW_W]};
    assign scale_a = s_tdata[sdc_pkg::A_SCL_LSB +: sdc_pkg::SCALE_W];
    assign scale_b = s_tdata[sdc_pkg::B_SCL_LSB +: sdc_pkg::SCALE_W];

    assign s_tready = (state_reg == sdc_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    sdc_align_unit #(
        .MAX_SCALE (MAX_SCALE),
        .WORK_BITS (WORK_BITS)
    ) u_align (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .mant_a  (mant_a),
        .mant_b  (mant_b),
        .scale_a (scale_a),
        .scale_b (scale_b),
        .stat    (stat),
        .mag_a   (mag_a),
        .mag_b   (mag_b)
    );

    sdc_order #(
        .WORK_BITS (WORK_BITS)
    ) u_order (
        .mag_a (mag_a),
        .mag_b (mag_b),
        .neg_a (neg_a_reg),
        .neg_b (neg_b_reg),
        .order (cmp_order)
    );

    // sequencer: load, step until aligned, compare into the output register
    always_comb begin
        state_next    = state_reg;
        order_next    = order_reg;
        m_tvalid_next = m_tvalid_reg;
        neg_a_next    = neg_a_reg;
        neg_b_next    = neg_b_reg;
        ctrl.load     = 1'b0;
        ctrl.step     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sdc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    ctrl.load  = 1'b1;
                    neg_a_next = s_tdata[sdc_pkg::A_NEG_LSB];
                    neg_b_next = s_tdata[sdc_pkg::B_NEG_LSB];
                    state_next = sdc_pkg::ST_ALIGN;
                end
            end
            sdc_pkg::ST_ALIGN: begin
                if (stat.done) begin
                    state_next = sdc_pkg::ST_CMP;
                end else begin
                    ctrl.step = 1'b1;
                end
            end
            sdc_pkg::ST_CMP: begin
                // wait here until the previous result has been taken
                if (out_free) begin
                    order_next    = cmp_order;
                    m_tvalid_next = 1'b1;
                    state_next    = sdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sdc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        order_reg <= order_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = sdc_pkg::M_TDATA_W'(order_reg);

    // an accepted item always leaves idle for alignment
    a_accept_align: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == sdc_pkg::ST_ALIGN))
        else $error("accepted item did not start alignment");

    // a fresh result only comes from the compare step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg || m_tready) ##1 m_tvalid_reg
            |-> ($past(state_reg) == sdc_pkg::ST_CMP))
        else $error("result produced outside compare step");

    // code 3 is never delivered
    a_order_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (order_reg != 2'd3))
        else $error("invalid order code");

    // compare is only entered once the scales are aligned
    a_cmp_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdc_pkg::ST_CMP) |-> stat.done)
        else $error("compare reached before alignment finished");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for scaled_decimal_compare_unit
// Drives operand pairs over the input stream and checks every order result
// against a local predictor; random idling on both sides, a long output
// hold-off, a pause to drain, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

    localparam int WORK_W       = sdc_pkg::DEF_WORK_BITS;
    localparam int MAX_SCL      = sdc_pkg::DEF_MAX_SCALE;
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int STALL_LIMIT  = 4000;  // cycles without any transfer
    localparam int TAIL_CYCLES  = 64;    // idle tail after the last test

    // mirrors the s_tdata layout; mantissa high word sits above the low word
    typedef struct packed {
        logic [sdc_pkg::S_TDATA_W-sdc_pkg::IN_BITS-1:0] pad;
        logic                                           b_neg;
        logic [sdc_pkg::SCALE_W-1:0]                    b_scale;
        logic [sdc_pkg::MANT_W-1:0]                     b_mant;
        logic                                           a_neg;
        logic [sdc_pkg::SCALE_W-1:0]                    a_scale;
        logic [sdc_pkg::MANT_W-1:0]                     a_mant;
    } operands_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [sdc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sdc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    sdc_pkg::order_t pending_orders[$];   // predicted orders, oldest first
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    bit     idle_en        = 1'b1;
    bit     hold_req       = 1'b0;

    always #1 aclk = ~aclk;

    scaled_decimal_compare_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ------------------------------------------------------------------------
    // Predictor: align the smaller scale by x*10 = (x<<3)+(x<<1), then
    // compare sign first and magnitude second; both-negative flips the order.
    // ------------------------------------------------------------------------
    function automatic sdc_pkg::order_t decimal_order(operands_t x);
        logic [WORK_W-1:0] ma;
        logic [WORK_W-1:0] mb;
        int                sa;
        int                sb;
        ma = WORK_W'(x.a_mant);
        mb = WORK_W'(x.b_mant);
        sa = (x.a_scale > MAX_SCL) ? MAX_SCL : int'(x.a_scale);
        sb = (x.b_scale > MAX_SCL) ? MAX_SCL : int'(x.b_scale);
        while (sa < sb) begin
            ma = (ma << 3) + (ma << 1);
            sa++;
        end
        while (sb < sa) begin
            mb = (mb << 3) + (mb << 1);
            sb++;
        end
        // signed zeros are all equal
        if (ma == '0 && mb == '0)
            return sdc_pkg::ORD_EQUAL;
        if (x.a_neg != x.b_neg)
            return x.a_neg ? sdc_pkg::ORD_LESS : sdc_pkg::ORD_GREATER;
        if (ma == mb)
            return sdc_pkg::ORD_EQUAL;
        return ((ma > mb) ^ x.a_neg) ? sdc_pkg::ORD_GREATER : sdc_pkg::ORD_LESS;
    endfunction

    function automatic logic [sdc_pkg::MANT_W-1:0] pow10(int k);
        logic [sdc_pkg::MANT_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // random mantissa, often short so that small values show up too
    function automatic logic [sdc_pkg::MANT_W-1:0] rand_mant();
        logic [sdc_pkg::MANT_W-1:0] m;
        m = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 1))
            m = m >> $urandom_range(0, sdc_pkg::MANT_W - 1);
        return m;
    endfunction

    function automatic operands_t pair_of(logic [sdc_pkg::MANT_W-1:0] am, int as, bit an,
                                          logic [sdc_pkg::MANT_W-1:0] bm, int bs, bit bn);
        operands_t x;
        x         = '0;
        x.a_mant  = am;
        x.a_scale = sdc_pkg::SCALE_W'(as);
        x.a_neg   = an;
        x.b_mant  = bm;
        x.b_scale = sdc_pkg::SCALE_W'(bs);
        x.b_neg   = bn;
        return x;
    endfunction

    function automatic operands_t random_operands();
        operands_t         x;
        operands_t         y;
        int                k;
        int                bits;
        int                sa;
        x       = '0;
        x.a_neg = 1'($urandom_range(0, 1));
        x.b_neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            4, 5, 6: begin
                // same value at two scales, maybe nudged by one unit
                k         = $urandom_range(0, 22);
                bits      = 92 - 4 * k;
                sa        = $urandom_range(0, MAX_SCL - k);
                x.a_mant  = rand_mant() & ((96'd1 << bits) - 1);
                x.a_scale = sdc_pkg::SCALE_W'(sa);
                x.b_mant  = x.a_mant * pow10(k);
                x.b_scale = sdc_pkg::SCALE_W'(sa + k);
                if (sa + k == MAX_SCL && $urandom_range(0, 1))
                    x.b_scale = sdc_pkg::SCALE_W'($urandom_range(MAX_SCL, 31));
                case ($urandom_range(0, 3))
                    1: x.b_mant = x.b_mant + 1;
                    2: if (x.b_mant != '0) x.b_mant = x.b_mant - 1;
                    default: ;
                endcase
                x.b_neg = ($urandom_range(0, 3) == 0) ? !x.a_neg : x.a_neg;
                if ($urandom_range(0, 1)) begin
                    y = x;
                    x = pair_of(y.b_mant, y.b_scale, y.b_neg,
                                y.a_mant, y.a_scale, y.a_neg);
                end
            end
            7: begin
                // zero on one side or both
                x.a_mant  = $urandom_range(0, 1) ? '0 : rand_mant();
                x.b_mant  = (x.a_mant != '0 || $urandom_range(0, 1)) ? '0 : rand_mant();
                x.a_scale = sdc_pkg::SCALE_W'($urandom_range(0, 31));
                x.b_scale = sdc_pkg::SCALE_W'($urandom_range(0, 31));
            end
            8: begin
                // same scale, mantissas one bit apart
                x.a_mant  = rand_mant();
                x.b_mant  = x.a_mant ^ (96'd1 << $urandom_range(0, sdc_pkg::MANT_W - 1));
                x.a_scale = sdc_pkg::SCALE_W'($urandom_range(0, 31));
                x.b_scale = x.a_scale;
            end
            9: begin
                // scale codes around and above the saturation limit
                x.a_mant  = rand_mant();
                x.b_mant  = rand_mant();
                x.a_scale = sdc_pkg::SCALE_W'($urandom_range(MAX_SCL - 2, 31));
                x.b_scale = sdc_pkg::SCALE_W'($urandom_range(MAX_SCL - 2, 31));
            end
            default: begin
                x.a_mant  = rand_mant();
                x.b_mant  = rand_mant();
                x.a_scale = sdc_pkg::SCALE_W'($urandom_range(0, 31));
                x.b_scale = sdc_pkg::SCALE_W'($urandom_range(0, 31));
            end
        endcase
        return x;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. s_tvalid stays high from one item to the next; a gap or
    // end_burst lowers it on a later edge, never on the edge that raises it.
    // ------------------------------------------------------------------------
    task automatic send_item(operands_t x);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tdata  <= x;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_orders.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready bursts, or one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each output transfer
    // against the oldest prediction, and runs the stall watchdog. Values are
    // the ones settled before the edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        sdc_pkg::order_t want;
        sdc_pkg::order_t got;
        bit              moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready === 1'b1) begin
                pending_orders.push_back(decimal_order(operands_t'(s_tdata)));
                moved = 1'b1;
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                moved = 1'b1;
                got   = sdc_pkg::order_t'(m_tdata[1:0]);
                if (pending_orders.size() == 0) begin
                    $error("order: expected none, got %0d", got);
                    mismatch_count++;
                end else begin
                    want = pending_orders.pop_front();
                    if (got !== want) begin
                        $error("order: expected %0d, got %0d", want, got);
                        mismatch_count++;
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("scaled_decimal_compare_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zeros, extremes, exact alignment, saturation, sign handling
    task automatic test_corner_values();
        operands_t                  corner_items[$];
        logic [sdc_pkg::MANT_W-1:0] top;
        logic [sdc_pkg::MANT_W-1:0] e28;
        top = '1;
        e28 = pow10(28);
        corner_items.push_back(pair_of(0, 0, 0, 0, 0, 0));
        corner_items.push_back(pair_of(0, 5, 1, 0, 28, 0));      // -0 vs +0
        corner_items.push_back(pair_of(0, 0, 0, 0, 31, 1));      // +0 vs -0
        corner_items.push_back(pair_of(0, 3, 1, 0, 17, 1));
        corner_items.push_back(pair_of(0, 0, 0, 1, 0, 0));       // zero vs nonzero
        corner_items.push_back(pair_of(0, 0, 1, 1, 0, 1));
        corner_items.push_back(pair_of(top, 0, 1, 0, 0, 0));
        corner_items.push_back(pair_of(top, 0, 0, top, 28, 0));  // widest alignment
        corner_items.push_back(pair_of(top, 28, 0, top, 0, 0));
        corner_items.push_back(pair_of(top, 0, 1, top, 28, 1));
        corner_items.push_back(pair_of(1, 0, 0, e28, 28, 0));    // exact equal
        corner_items.push_back(pair_of(1, 0, 1, e28, 28, 1));
        corner_items.push_back(pair_of(1, 0, 0, e28 + 1, 28, 0));
        corner_items.push_back(pair_of(1, 0, 1, e28 + 1, 28, 1));
        corner_items.push_back(pair_of(7, 31, 0, 7, 28, 0));     // saturated scale
        corner_items.push_back(pair_of(7, 30, 0, 70, 27, 0));
        corner_items.push_back(pair_of(top, 31, 0, top, 29, 0));
        corner_items.push_back(pair_of(96'd1 << 95, 9, 0, (96'd1 << 95) - 1, 9, 0));
        corner_items.push_back(pair_of(2, 14, 0, 3, 14, 0));
        corner_items.push_back(pair_of(3, 0, 1, 2, 0, 0));       // sign decides
        corner_items.push_back(pair_of(2, 0, 0, 3, 0, 1));
        corner_items.push_back(pair_of(5, 1, 1, 50, 2, 1));
        corner_items.push_back(pair_of(top, 0, 0, top, 0, 1));
        foreach (corner_items[i])
            send_item(corner_items[i]);
        end_burst();
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
            send_item(random_operands());
        end_burst();
        wait_drained();
    endtask

    // receiver holds off while items keep coming, so the input backs up
    task automatic test_output_backpressure();
        bit saved_idle;
        saved_idle = idle_en;
        idle_en    = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(random_operands());
        end_burst();
        wait_drained();
        idle_en = saved_idle;
    endtask

    // sender stops after every tenth item and waits for every result before going on
    task automatic test_pause_until_drained();
        for (int i = 0; i < 40; i++) begin
            send_item(random_operands());
            if (i % 10 == 9) begin
                end_burst();
                wait_drained();
            end
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_full_rate(int n);
        idle_en = 1'b0;
        test_random_traffic(n);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_values();
        test_random_traffic(480);
        test_output_backpressure();
        test_pause_until_drained();
        test_full_rate(250);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("scaled_decimal_compare_unit verification clean");
        else
            $display("scaled_decimal_compare_unit verification failed");
        $finish;
    end

endmodule
